### hdl/ksb64_pkg.sv
// Shared types, constants and helpers for the keyed shuffled base64 decoder.
// No dependencies; used by ksb64_ctrl, ksb64_dp and the top level.
`default_nettype none

package ksb64_pkg;

    localparam int          DEF_MAX_KEY_LEN = 128;
    localparam int          TBL_DEPTH       = 64;
    localparam int          TBL_AW          = 6;
    localparam logic [5:0]  TBL_LAST        = 6'd63;
    localparam logic [2:0]  SEED_LEN        = 3'd5;
    localparam logic [2:0]  SEED_LAST       = 3'd4;
    localparam logic [7:0]  NEWLINE_BYTE    = 8'h0A;
    localparam logic [7:0]  MARK_OFFSET     = 8'd63;
    localparam logic [8*64-1:0] ALPHA_STR =
        "AZERTYUIOPQSDFGHJKLMWXCVBNazertyuiopqsdfghjklmwxcvbn0123456789+/";

    // first character sits in the top byte of the string constant
    function automatic logic [7:0] alpha_at(input logic [5:0] idx);
        logic [5:0] r;
        r = TBL_LAST - idx;
        return ALPHA_STR[{r, 3'b000} +: 8];
    endfunction

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_KEY_WR,
        OP_RESTART,
        OP_SEED_WR,
        OP_RD_LAST,
        OP_MARKER,
        OP_SRCH_START,
        OP_SRCH_STEP,
        OP_DROP,
        OP_EMIT,
        OP_SW_KEY,
        OP_SW_RD,
        OP_SW_WR1,
        OP_SW_WR2
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } cmd_t;

    typedef struct packed {
        logic kind;
        logic first;
        logic seed_phase;
        logic seed_last;
        logic newline;
        logic hit;
        logic srch_end;
        logic out_free;
        logic cnt_wrap;
        logic key_empty;
        logic swap_done;
    } stat_t;

endpackage

`default_nettype wire

### hdl/keyed_shuffled_base64_decoder.sv
// Keyed shuffled base64 decoder: top level joining controller and datapath.
// Depends on ksb64_pkg, ksb64_ctrl and ksb64_dp.
//
// Input stream: s_tdata carries the raw byte, s_tuser[0] says key byte (0) or
// ciphertext byte (1), s_tuser[1] marks the first byte of a key or a message.
// Output stream: m_tdata carries one decoded plaintext byte.
// One request is worked on at a time; s_tready is high only when idle.
// Per request: a key byte is stored while the key memory has room; a seed
// byte is stored, and the fifth seed byte adds a 64-swap pass driven by the
// seed. A newline is dropped. Any other ciphertext byte is first compared
// with the last table entry (a marker); else the lookup walks the single
// table memory from entry 0 until the byte is found or the end is reached.
// A marker byte, and every 64th output, trigger a key rescramble when the
// key is not empty: a 64-swap pass, repeated when the key holds 128 or more
// bytes. Each swap reads both entries, then writes each back.
// Reset: the table returns to the fixed alphabet, key length, position,
// counter and offset go to zero. When m_tready is low the decoded byte waits
// in the output register; the block still accepts the next request and only
// halts if that one also produces a byte before the first is taken.
`default_nettype none

module keyed_shuffled_base64_decoder #(
    parameter int MAX_KEY_LEN = ksb64_pkg::DEF_MAX_KEY_LEN
) (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        s_tvalid,
    output logic       s_tready,
    input  wire  [7:0] s_tdata,   // [7:0] data_byte
    input  wire  [1:0] s_tuser,   // [0] kind, [1] first
    output logic       m_tvalid,
    input  wire        m_tready,
    output logic [7:0] m_tdata    // [7:0] plain_byte
);

    ksb64_pkg::cmd_t  cmd;
    ksb64_pkg::stat_t st;

    ksb64_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    ksb64_dp #(
        .MAX_KEY_LEN (MAX_KEY_LEN)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .st       (st),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

### hdl/ksb64_ctrl.sv
// Controller state machine of the decoder: sequences capture, seed, lookup,
// output and table swap steps. Depends on ksb64_pkg.
`default_nettype none

module ksb64_ctrl (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              s_tvalid,
    output logic             s_tready,
    input  ksb64_pkg::stat_t st,
    output ksb64_pkg::cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_MSG,
        S_CHK_LAST,
        S_SEARCH,
        S_EMIT,
        S_SW_KEY,
        S_SW_RD,
        S_SW_WR1,
        S_SW_WR2
    } state_t;

    state_t state_reg, state_next;
    logic   rdy_reg, rdy_next;
    ksb64_pkg::dp_op_t op;

    always_comb
    begin
        state_next = state_reg;
        op         = ksb64_pkg::OP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid && rdy_reg)
                begin
                    op         = ksb64_pkg::OP_CAPTURE;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (!st.kind)
                begin
                    op         = ksb64_pkg::OP_KEY_WR;
                    state_next = S_IDLE;
                end
                else if (st.first)
                begin
                    op         = ksb64_pkg::OP_RESTART;
                    state_next = S_MSG;
                end
                else
                begin
                    state_next = S_MSG;
                end
            end
            S_MSG:
            begin
                if (st.seed_phase)
                begin
                    op         = ksb64_pkg::OP_SEED_WR;
                    state_next = st.seed_last ? S_SW_KEY : S_IDLE;
                end
                else if (st.newline)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    op         = ksb64_pkg::OP_RD_LAST;
                    state_next = S_CHK_LAST;
                end
            end
            S_CHK_LAST:
            begin
                if (st.hit)
                begin
                    op         = ksb64_pkg::OP_MARKER;
                    state_next = st.key_empty ? S_IDLE : S_SW_KEY;
                end
                else
                begin
                    op         = ksb64_pkg::OP_SRCH_START;
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (st.hit)
                begin
                    state_next = S_EMIT;
                end
                else if (st.srch_end)
                begin
                    op         = ksb64_pkg::OP_DROP;
                    state_next = S_IDLE;
                end
                else
                begin
                    op = ksb64_pkg::OP_SRCH_STEP;
                end
            end
            S_EMIT:
            begin
                if (st.out_free)
                begin
                    op         = ksb64_pkg::OP_EMIT;
                    state_next = (st.cnt_wrap && !st.key_empty) ? S_SW_KEY : S_IDLE;
                end
            end
            S_SW_KEY:
            begin
                op         = ksb64_pkg::OP_SW_KEY;
                state_next = S_SW_RD;
            end
            S_SW_RD:
            begin
                op         = ksb64_pkg::OP_SW_RD;
                state_next = S_SW_WR1;
            end
            S_SW_WR1:
            begin
                op         = ksb64_pkg::OP_SW_WR1;
                state_next = S_SW_WR2;
            end
            S_SW_WR2:
            begin
                op         = ksb64_pkg::OP_SW_WR2;
                state_next = st.swap_done ? S_IDLE : S_SW_KEY;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        rdy_next = (state_next == S_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rdy_reg   <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            rdy_reg   <= rdy_next;
        end
    end

    assign s_tready = rdy_reg;
    assign cmd.op   = op;

endmodule

`default_nettype wire

### hdl/ksb64_dp.sv
// Datapath of the decoder: symbol table memory, key memory, seed registers,
// counters, offset and output register. Depends on ksb64_pkg.
`default_nettype none

module ksb64_dp #(
    parameter int MAX_KEY_LEN = ksb64_pkg::DEF_MAX_KEY_LEN
) (
    input  wire              clk,
    input  wire              rst_n,
    input  ksb64_pkg::cmd_t  cmd,
    output ksb64_pkg::stat_t st,
    input  wire  [7:0]       s_tdata,
    input  wire  [1:0]       s_tuser,
    output logic             m_tvalid,
    input  wire              m_tready,
    output logic [7:0]       m_tdata
);

    localparam int KLEN_W = $clog2(MAX_KEY_LEN + 1);
    localparam int KA_W   = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;
    localparam int K_W    = (KLEN_W > 3) ? KLEN_W : 3;
    localparam logic [KLEN_W-1:0] KEY_MAX = KLEN_W'(MAX_KEY_LEN);
    localparam int TBL_DEPTH_L = ksb64_pkg::TBL_DEPTH;

    // item registers
    logic              kind_reg, kind_next;
    logic              first_reg, first_next;
    logic [7:0]        byte_reg, byte_next;

    logic [KLEN_W-1:0] key_len_reg, key_len_next;
    logic [2:0]        pos_reg, pos_next;
    logic [5:0]        cnt_reg, cnt_next;
    logic [7:0]        ofs_reg, ofs_next;
    logic [5:0]        idx_reg, idx_next;

    // swap walk
    logic [5:0]        swi_reg, swi_next;
    logic [5:0]        swj_reg, swj_next;
    logic [K_W-1:0]    k_reg, k_next;
    logic [K_W-1:0]    scr_len_reg, scr_len_next;
    logic              pass_reg, pass_next;
    logic              two_pass_reg, two_pass_next;
    logic              src_seed_reg, src_seed_next;
    logic [7:0]        scr_byte_reg;
    logic              scr_ld;

    logic [7:0]        out_reg, out_next;
    logic              ovalid_reg, ovalid_next;

    // symbol table: valid bit set means the memory entry overrides the alphabet
    logic [7:0]        tbl_mem [TBL_DEPTH_L];
    logic [63:0]       tvalid_reg, tvalid_next;
    logic              tbl_we, tbl_re;
    logic [5:0]        tbl_wa, tbl_ra, tbl_rb;
    logic [7:0]        tbl_wd;
    logic [7:0]        rd_a_reg, rd_b_reg;

    logic [7:0]        key_mem [MAX_KEY_LEN];
    logic              key_we;
    logic [KA_W-1:0]   key_wa;

    logic [7:0]        seed_reg [5];
    logic              seed_we;

    logic [KLEN_W-1:0] eff_len;
    logic [K_W-1:0]    k_inc;
    logic [5:0]        j_calc;

    always_comb
    begin
        kind_next     = kind_reg;
        first_next    = first_reg;
        byte_next     = byte_reg;
        key_len_next  = key_len_reg;
        pos_next      = pos_reg;
        cnt_next      = cnt_reg;
        ofs_next      = ofs_reg;
        idx_next      = idx_reg;
        swi_next      = swi_reg;
        swj_next      = swj_reg;
        k_next        = k_reg;
        scr_len_next  = scr_len_reg;
        pass_next     = pass_reg;
        two_pass_next = two_pass_reg;
        src_seed_next = src_seed_reg;
        out_next      = out_reg;
        ovalid_next   = ovalid_reg && !m_tready;
        tvalid_next   = tvalid_reg;
        tbl_we        = 1'b0;
        tbl_re        = 1'b0;
        tbl_wa        = swi_reg;
        tbl_wd        = rd_b_reg;
        tbl_ra        = swi_reg;
        tbl_rb        = swi_reg;
        key_we        = 1'b0;
        seed_we       = 1'b0;
        scr_ld        = 1'b0;
        eff_len       = first_reg ? '0 : key_len_reg;
        key_wa        = eff_len[KA_W-1:0];
        k_inc         = k_reg + 1'b1;
        j_calc        = scr_byte_reg[5:0] + swi_reg;

        case (cmd.op)
            ksb64_pkg::OP_CAPTURE:
            begin
                kind_next  = s_tuser[0];
                first_next = s_tuser[1];
                byte_next  = s_tdata;
            end
            ksb64_pkg::OP_KEY_WR:
            begin
                key_len_next = eff_len;
                if (eff_len < KEY_MAX)
                begin
                    key_we       = 1'b1;
                    key_len_next = eff_len + 1'b1;
                end
            end
            ksb64_pkg::OP_RESTART:
            begin
                tvalid_next = '0;
                pos_next    = '0;
                cnt_next    = '0;
                ofs_next    = '0;
            end
            ksb64_pkg::OP_SEED_WR:
            begin
                seed_we       = 1'b1;
                pos_next      = pos_reg + 1'b1;
                swi_next      = '0;
                k_next        = '0;
                pass_next     = 1'b0;
                two_pass_next = 1'b0;
                src_seed_next = 1'b1;
                scr_len_next  = K_W'(ksb64_pkg::SEED_LEN);
            end
            ksb64_pkg::OP_RD_LAST:
            begin
                tbl_re = 1'b1;
                tbl_ra = ksb64_pkg::TBL_LAST;
            end
            ksb64_pkg::OP_MARKER,
            ksb64_pkg::OP_EMIT:
            begin
                if (cmd.op == ksb64_pkg::OP_MARKER)
                begin
                    ofs_next = ofs_reg + ksb64_pkg::MARK_OFFSET;
                end
                else
                begin
                    out_next    = ofs_reg + {2'b00, idx_reg};
                    ovalid_next = 1'b1;
                    ofs_next    = '0;
                    cnt_next    = cnt_reg + 1'b1;
                end
                swi_next      = '0;
                k_next        = '0;
                pass_next     = 1'b0;
                src_seed_next = 1'b0;
                scr_len_next  = K_W'(key_len_reg);
                two_pass_next = (32'(key_len_reg) >= 32'd128);
            end
            ksb64_pkg::OP_SRCH_START:
            begin
                tbl_re   = 1'b1;
                tbl_ra   = '0;
                idx_next = '0;
            end
            ksb64_pkg::OP_SRCH_STEP:
            begin
                tbl_re   = 1'b1;
                tbl_ra   = idx_reg + 1'b1;
                idx_next = idx_reg + 1'b1;
            end
            ksb64_pkg::OP_DROP:
            begin
                ofs_next = '0;
            end
            ksb64_pkg::OP_SW_KEY:
            begin
                scr_ld = 1'b1;
            end
            ksb64_pkg::OP_SW_RD:
            begin
                tbl_re   = 1'b1;
                tbl_ra   = swi_reg;
                tbl_rb   = j_calc;
                swj_next = j_calc;
            end
            ksb64_pkg::OP_SW_WR1:
            begin
                tbl_we = 1'b1;
                tbl_wa = swi_reg;
                tbl_wd = rd_b_reg;
            end
            ksb64_pkg::OP_SW_WR2:
            begin
                tbl_we   = 1'b1;
                tbl_wa   = swj_reg;
                tbl_wd   = rd_a_reg;
                swi_next = swi_reg + 1'b1;
                k_next   = (k_inc >= scr_len_reg) ? '0 : k_inc;
                if (swi_reg == ksb64_pkg::TBL_LAST)
                begin
                    pass_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        if (tbl_we)
        begin
            tvalid_next[tbl_wa] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_len_reg <= '0;
            pos_reg     <= '0;
            cnt_reg     <= '0;
            ofs_reg     <= '0;
            pass_reg    <= 1'b0;
            ovalid_reg  <= 1'b0;
            tvalid_reg  <= '0;
        end
        else
        begin
            key_len_reg <= key_len_next;
            pos_reg     <= pos_next;
            cnt_reg     <= cnt_next;
            ofs_reg     <= ofs_next;
            pass_reg    <= pass_next;
            ovalid_reg  <= ovalid_next;
            tvalid_reg  <= tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        first_reg    <= first_next;
        byte_reg     <= byte_next;
        idx_reg      <= idx_next;
        swi_reg      <= swi_next;
        swj_reg      <= swj_next;
        k_reg        <= k_next;
        scr_len_reg  <= scr_len_next;
        two_pass_reg <= two_pass_next;
        src_seed_reg <= src_seed_next;
        out_reg      <= out_next;
    end

    // table memory: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            tbl_mem[tbl_wa] <= tbl_wd;
        end
        if (tbl_re)
        begin
            rd_a_reg <= tvalid_reg[tbl_ra] ? tbl_mem[tbl_ra] : ksb64_pkg::alpha_at(tbl_ra);
            rd_b_reg <= tvalid_reg[tbl_rb] ? tbl_mem[tbl_rb] : ksb64_pkg::alpha_at(tbl_rb);
        end
    end

    // key memory and seed bytes; the swap byte is registered ahead of the table read that uses it
    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[key_wa] <= byte_reg;
        end
        if (seed_we)
        begin
            seed_reg[pos_reg] <= byte_reg;
        end
        if (scr_ld)
        begin
            scr_byte_reg <= src_seed_reg ? seed_reg[k_reg[2:0]] : key_mem[k_reg[KA_W-1:0]];
        end
    end

    assign st.kind       = kind_reg;
    assign st.first      = first_reg;
    assign st.seed_phase = (pos_reg < ksb64_pkg::SEED_LEN);
    assign st.seed_last  = (pos_reg == ksb64_pkg::SEED_LAST);
    assign st.newline    = (byte_reg == ksb64_pkg::NEWLINE_BYTE);
    assign st.hit        = (rd_a_reg == byte_reg);
    assign st.srch_end   = (idx_reg == ksb64_pkg::TBL_LAST);
    assign st.out_free   = !ovalid_reg || m_tready;
    assign st.cnt_wrap   = (cnt_reg == ksb64_pkg::TBL_LAST);
    assign st.key_empty  = (key_len_reg == '0);
    assign st.swap_done  = (swi_reg == ksb64_pkg::TBL_LAST) && (pass_reg || !two_pass_reg);

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = out_reg;

endmodule

`default_nettype wire

### hdl/ksb64_chk.sv
// Port-level checker for the decoder, bound to the top level.
// Depends only on the top-level port list.
`default_nettype none

module ksb64_chk (
    input wire       clk,
    input wire       rst_n,
    input wire       s_tvalid,
    input wire       s_tready,
    input wire [7:0] s_tdata,
    input wire [1:0] s_tuser,
    input wire       m_tvalid,
    input wire       m_tready,
    input wire [7:0] m_tdata
);

    // a stalled output byte holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output byte changed while stalled");

    // one request at a time
    a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after a request");

    // a new output byte only appears while a request is being worked on
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("output byte raised while idle");

    // a key byte never yields an output
    a_key_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !s_tuser[0] |-> ##2 !$rose(m_tvalid))
        else $error("key byte produced output");

endmodule

bind keyed_shuffled_base64_decoder ksb64_chk u_ksb64_chk (.*);

`default_nettype wire

### test/tb.sv
// Testbench for keyed_shuffled_base64_decoder: random and directed key and
// ciphertext streams, checked against a predictor in the bench.
// Depends on ksb64_pkg and the decoder RTL.
module tb;

    localparam int MAX_KEY     = ksb64_pkg::DEF_MAX_KEY_LEN;
    localparam int HOLD_CYCLES = 3000;
    localparam int SETTLE      = 1000;
    localparam int DRAIN_LIMIT = 200000;

    typedef struct packed {
        logic       first;
        logic       kind;
        logic [7:0] data;
    } req_t;

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;  // [7:0] data_byte
    logic [1:0] s_tuser  = 2'b00;  // [0] kind, [1] first
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;           // [7:0] plain_byte

    keyed_shuffled_base64_decoder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor state
    logic [7:0] sym_tbl [ksb64_pkg::TBL_DEPTH];
    logic [7:0] key_q [$];
    logic [7:0] seed_q [$];
    logic [5:0] out_cnt;
    logic [7:0] off_acc;

    req_t       req_q [$];
    logic [7:0] plain_q [$];
    int         pushed         = 0;
    int         err_cnt        = 0;
    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;
    int         hold_req       = 0;
    int         hold_ack       = 0;
    int         hold_left      = 0;

    task automatic flag_error(input string msg);
        err_cnt++;
        if (err_cnt <= 10)
            $display("%s", msg);
    endtask

    function automatic void fresh_table();
        for (int i = 0; i < ksb64_pkg::TBL_DEPTH; i++)
            sym_tbl[i] = ksb64_pkg::ALPHA_STR[8*(ksb64_pkg::TBL_DEPTH-1-i) +: 8];
        seed_q.delete();
        out_cnt = '0;
        off_acc = '0;
    endfunction

    // swap walk over the table, bytes taken cyclically from key or seed
    function automatic void shuffle_pass(input bit from_seed, input int passes);
        int         len;
        int         k;
        int         j;
        logic [7:0] kb;
        logic [7:0] t;
        len = from_seed ? seed_q.size() : key_q.size();
        k = 0;
        if (len == 0)
            return;
        for (int p = 0; p < passes; p++)
            for (int i = 0; i < ksb64_pkg::TBL_DEPTH; i++)
            begin
                kb = from_seed ? seed_q[k] : key_q[k];
                j = (int'(kb) + i) & (ksb64_pkg::TBL_DEPTH - 1);
                t = sym_tbl[i];
                sym_tbl[i] = sym_tbl[j];
                sym_tbl[j] = t;
                k++;
                if (k >= len)
                    k = 0;
            end
    endfunction

    function automatic void key_shuffle();
        shuffle_pass(1'b0, key_q.size() / 128 + 1);
    endfunction

    function automatic bit decode_byte(input logic kind, input logic [7:0] b,
                                       input logic first, output logic [7:0] plain);
        int idx;
        plain = '0;
        if (!kind)
        begin
            if (first)
                key_q.delete();
            if (key_q.size() < MAX_KEY)
                key_q.insert(key_q.size(), b);
            return 1'b0;
        end
        if (first)
            fresh_table();
        if (seed_q.size() < ksb64_pkg::SEED_LEN)
        begin
            seed_q.insert(seed_q.size(), b);
            if (seed_q.size() == ksb64_pkg::SEED_LEN)
                shuffle_pass(1'b1, 1);
            return 1'b0;
        end
        if (b == ksb64_pkg::NEWLINE_BYTE)
            return 1'b0;
        if (b == sym_tbl[ksb64_pkg::TBL_DEPTH-1])
        begin
            off_acc = off_acc + ksb64_pkg::MARK_OFFSET;
            key_shuffle();
            return 1'b0;
        end
        idx = -1;
        for (int i = 0; i < ksb64_pkg::TBL_DEPTH; i++)
            if (idx < 0 && sym_tbl[i] == b)
                idx = i;
        if (idx < 0)
        begin
            off_acc = '0;
            return 1'b0;
        end
        plain = off_acc + 8'(idx);
        off_acc = '0;
        out_cnt = out_cnt + 6'd1;
        if (out_cnt == 6'd0)
            key_shuffle();
        return 1'b1;
    endfunction

    task automatic push_req(input logic kind, input logic [7:0] b, input logic first);
        logic [7:0] plain;
        req_q.insert(req_q.size(), req_t'{first: first, kind: kind, data: b});
        pushed++;
        if (decode_byte(kind, b, first, plain))
            plain_q.insert(plain_q.size(), plain);
    endtask

    // a byte that is neither a table symbol nor a newline
    function automatic logic [7:0] stray_byte();
        logic [7:0] b;
        bit         hit;
        do
        begin
            b = 8'($urandom);
            hit = (b == ksb64_pkg::NEWLINE_BYTE);
            for (int i = 0; i < ksb64_pkg::TBL_DEPTH; i++)
                if (sym_tbl[i] == b)
                    hit = 1'b1;
        end
        while (hit);
        return b;
    endfunction

    task automatic push_key(input int n);
        for (int i = 0; i < n; i++)
            push_req(1'b0, 8'($urandom), (i == 0) && ($urandom_range(4) != 0));
    endtask

    task automatic push_body(input int n);
        int r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            if (r < 68)
                push_req(1'b1, sym_tbl[$urandom_range(ksb64_pkg::TBL_DEPTH-2)], 1'b0);
            else if (r < 74)
                push_req(1'b1, sym_tbl[ksb64_pkg::TBL_DEPTH-1], 1'b0);
            else if (r < 80)
                push_req(1'b1, ksb64_pkg::NEWLINE_BYTE, 1'b0);
            else if (r < 88)
                push_req(1'b1, stray_byte(), 1'b0);
            else if (r < 99)
                push_req(1'b1, 8'($urandom), 1'b0);
            else
                push_key($urandom_range(1, 6));
        end
    endtask

    task automatic push_msg(input bit restart, input int body);
        if (restart)
            for (int i = 0; i < ksb64_pkg::SEED_LEN; i++)
                push_req(1'b1,
                         ($urandom_range(9) == 0) ? ksb64_pkg::NEWLINE_BYTE : 8'($urandom),
                         i == 0);
        push_body(body);
    endtask

    task automatic push_mix(input int n);
        int goal;
        int r;
        goal = pushed + n;
        while (pushed < goal)
        begin
            r = $urandom_range(99);
            if (r < 15)
                push_key($urandom_range(1, 12));
            else if (r < 85)
                push_msg(1'b1, $urandom_range(20, 150));
            else
                push_msg(1'b0, $urandom_range(5, 40));
        end
    endtask

    // wait for all requests to go in and all results to come out, then settle
    task automatic drain();
        int n;
        n = 0;
        while ((req_q.size() != 0 || s_tvalid || plain_q.size() != 0) && n < DRAIN_LIMIT)
        begin
            @(negedge clk);
            n++;
        end
        if (plain_q.size() != 0)
        begin
            flag_error($sformatf("%0d expected bytes never came out", plain_q.size()));
            plain_q.delete();
        end
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic set_idle(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin : drive
        req_t nxt;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= 8'h00;
            s_tuser <= 2'b00;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (req_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                nxt = req_q.pop_front();
                s_tdata <= nxt.data;
                s_tuser <= {nxt.first, nxt.kind};
                s_tvalid <= 1'b1;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result side ready, with an occasional long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            hold_left <= 0;
            hold_ack <= 0;
        end
        else if (hold_req != hold_ack)
        begin
            hold_ack <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin : watch
        logic [7:0] want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (plain_q.size() == 0)
            begin
                flag_error($sformatf("unexpected output byte %02h", m_tdata));
            end
            else
            begin
                want = plain_q.pop_front();
                if (m_tdata !== want)
                    flag_error($sformatf("plain_byte mismatch: expected %02h, got %02h",
                                         want, m_tdata));
            end
        end
    end

    initial
    begin
        #20000000;
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        fresh_table();
        key_q.delete();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // ciphertext before any restart or key: the first five bytes fill the seed and shuffle the table
        push_req(1'b1, 8'h00, 1'b0);
        push_req(1'b1, 8'hFF, 1'b0);
        push_req(1'b1, ksb64_pkg::NEWLINE_BYTE, 1'b0);
        push_req(1'b1, 8'h80, 1'b0);
        push_req(1'b1, 8'h7F, 1'b0);
        push_req(1'b1, ksb64_pkg::NEWLINE_BYTE, 1'b0);
        push_req(1'b1, sym_tbl[ksb64_pkg::TBL_DEPTH-1], 1'b0);
        push_req(1'b1, ksb64_pkg::NEWLINE_BYTE, 1'b0);     // offset survives the newline
        push_req(1'b1, sym_tbl[ksb64_pkg::TBL_DEPTH-2], 1'b0);
        for (int i = 0; i < 4; i++)
            push_req(1'b1, sym_tbl[ksb64_pkg::TBL_DEPTH-1], 1'b0);
        push_req(1'b1, sym_tbl[ksb64_pkg::TBL_DEPTH-2], 1'b0); // offset plus index wraps past 255
        push_req(1'b1, sym_tbl[ksb64_pkg::TBL_DEPTH-1], 1'b0);
        push_req(1'b1, stray_byte(), 1'b0);
        push_req(1'b1, sym_tbl[0], 1'b0);
        push_req(1'b0, 8'hFF, 1'b1);
        push_req(1'b0, 8'h00, 1'b0);
        push_req(1'b0, 8'h80, 1'b0);
        push_msg(1'b1, 0);
        push_req(1'b1, sym_tbl[ksb64_pkg::TBL_DEPTH-1], 1'b0);
        push_req(1'b1, sym_tbl[0], 1'b0);
        drain();

        set_idle(0, 0);
        push_mix(70);
        drain();
        set_idle(62, 0);
        push_mix(70);
        drain();
        set_idle(0, 62);
        push_mix(70);
        drain();
        set_idle(27, 27);
        push_mix(70);
        drain();

        // result side held off while requests keep coming
        set_idle(0, 0);
        hold_req = hold_req + 1;
        push_req(1'b1, 8'($urandom), 1'b1);
        for (int i = 1; i < ksb64_pkg::SEED_LEN; i++)
            push_req(1'b1, 8'($urandom), 1'b0);
        for (int i = 0; i < 40; i++)
            push_req(1'b1, sym_tbl[$urandom_range(ksb64_pkg::TBL_DEPTH-2)], 1'b0);
        drain();

        // key past the store size, then a short key again
        set_idle(27, 27);
        push_key(0);
        push_req(1'b0, 8'($urandom), 1'b1);
        push_key($urandom_range(128, 139));
        push_msg(1'b1, 40);
        push_req(1'b0, 8'($urandom), 1'b1);
        push_msg(1'b1, 30);
        drain();

        if (err_cnt == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule

### filelist.f
hdl/ksb64_pkg.sv
hdl/ksb64_ctrl.sv
hdl/ksb64_dp.sv
hdl/keyed_shuffled_base64_decoder.sv
hdl/ksb64_chk.sv
test/tb.sv
